// ===== sv/qse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, defaults and datapath command codes for the quicksort engine.
package qse_pkg;

    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // One command per cycle from the controller to the datapath.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT_PUSH,
        OP_POP,
        OP_LATCH_RANGE,
        OP_LATCH_PIVOT,
        OP_SCAN_READ,
        OP_SWAP_LO,
        OP_SWAP_HI,
        OP_SKIP,
        OP_FINAL_READ,
        OP_FINAL_LO,
        OP_FINAL_HI,
        OP_PUSH_RIGHT,
        OP_PUSH_LEFT,
        OP_OUT_READ,
        OP_OUT_LOAD,
        OP_OUT_NEXT,
        OP_CLEAR
    } qse_op_t;

    // Status flags from the datapath back to the controller.
    typedef struct packed {
        logic count_ge2;
        logic sp_zero;
        logic k_eq_hi;
        logic less;
        logic right_ok;
        logic left_ok;
        logic out_taken;
        logic out_last;
    } qse_status_t;

endpackage

// ===== sv/quicksort_engine_core.sv =====
`timescale 1ns / 1ps
// Top level of the quicksort engine: stream ports, controller and datapath.
//
// The engine collects a set of signed values, one per input transaction, into an on-chip
// store of MAX_ITEMS entries; the transaction with tlast set closes the set. It then sorts
// the set in ascending signed order with quicksort (Lomuto partition, last element of a
// range as pivot, pending ranges on a small stack) and streams the sorted values out, with
// tlast on the final one. Values arriving after the store is full are discarded, and every
// result of such a set carries tuser set. Loading accepts one transaction per cycle. Each
// range is popped from the stack and its pivot fetched; each element is then read and
// compared with the pivot, and each one below it is exchanged into the lower part at the
// cost of two writes, since the element memory has a single write port. The pivot is then
// placed and the subranges of two or more elements are pushed. Emission loads each result
// and holds it until the sink takes it. The input side is not ready while a set is being
// sorted or emitted.
module quicksort_engine_core
    import qse_pkg::*;
#(
    parameter int  MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int  DATA_WIDTH = DEF_DATA_WIDTH,
    localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [DATA_WIDTH-1:0] value, rest zero
    input  logic               s_tlast,   // last_item
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [DATA_WIDTH-1:0] sorted_value, rest zero
    output logic               m_tlast,   // last_result
    output logic [0:0]         m_tuser    // [0] dropped
);

    qse_op_t               op;
    qse_status_t           status;
    logic [DATA_WIDTH-1:0] m_value;
    logic                  m_user;

    // The controller sequences the load, the partition loop and the output stream.
    qse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    // The datapath holds the element memory, the range stack and the output register.
    qse_dpath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .s_value  (s_tdata[DATA_WIDTH-1:0]),
        .m_tready (m_tready),
        .m_valid  (m_tvalid),
        .m_value  (m_value),
        .m_last   (m_tlast),
        .m_user   (m_user),
        .status   (status)
    );

    // Sorted values are zero-padded up to the byte-aligned bus width.
    assign m_tdata    = TDATA_W'(m_value);
    assign m_tuser[0] = m_user;

endmodule

// ===== sv/qse_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the quicksort engine: element memory, range stack, indexes and output register.
module qse_dpath
    import qse_pkg::*;
#(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  qse_op_t               op,
    input  logic [DATA_WIDTH-1:0] s_value,
    input  logic                  m_tready,
    output logic                  m_valid,
    output logic [DATA_WIDTH-1:0] m_value,
    output logic                  m_last,
    output logic                  m_user,
    output qse_status_t           status
);

    localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [DATA_WIDTH-1:0] elem_mem [MAX_ITEMS];
    logic [2*IDX_W-1:0]    stk_mem  [MAX_ITEMS];

    logic [CNT_W-1:0]      count_reg;
    logic                  ovf_reg;
    logic [IDX_W-1:0]      sp_reg;
    logic [IDX_W-1:0]      out_idx_reg;
    logic                  m_valid_reg;
    logic [DATA_WIDTH-1:0] m_value_reg;
    logic                  m_last_reg;
    logic                  m_user_reg;

    logic [IDX_W-1:0]      lo_reg, hi_reg, k_reg, dest_reg;
    logic [DATA_WIDTH-1:0] pivot_reg, rd_a_reg, rd_b_reg;
    logic [2*IDX_W-1:0]    stk_rd_reg;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  rd_a_en, rd_b_en;
    logic [IDX_W-1:0]      rd_a_addr, rd_b_addr;
    logic                  stk_we, stk_re;
    logic [IDX_W-1:0]      stk_waddr;
    logic [2*IDX_W-1:0]    stk_wdata;

    logic [CNT_W-1:0]      cnt_m1;
    logic                  not_full;
    logic [IDX_W-1:0]      stk_lo, stk_hi;

    assign cnt_m1   = count_reg - CNT_W'(1);
    assign not_full = count_reg < CNT_W'(MAX_ITEMS);
    assign stk_lo   = stk_rd_reg[2*IDX_W-1:IDX_W];
    assign stk_hi   = stk_rd_reg[IDX_W-1:0];

    always_comb begin
        status.count_ge2 = count_reg >= CNT_W'(2);
        status.sp_zero   = sp_reg == '0;
        status.k_eq_hi   = k_reg == hi_reg;
        status.less      = $signed(rd_a_reg) < $signed(pivot_reg);
        status.right_ok  = ((IDX_W + 1)'(dest_reg) + (IDX_W + 1)'(1)) < (IDX_W + 1)'(hi_reg);
        status.left_ok   = (IDX_W + 1)'(dest_reg) > ((IDX_W + 1)'(lo_reg) + (IDX_W + 1)'(1));
        status.out_taken = m_valid_reg && m_tready;
        status.out_last  = m_last_reg;
    end

    // Memory port steering.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = dest_reg;
        mem_wdata = rd_a_reg;
        rd_a_en   = 1'b0;
        rd_a_addr = k_reg;
        rd_b_en   = 1'b0;
        rd_b_addr = dest_reg;
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_waddr = sp_reg;
        stk_wdata = {lo_reg, hi_reg};
        unique case (op)
            OP_LOAD: begin
                mem_we    = not_full;
                mem_waddr = count_reg[IDX_W-1:0];
                mem_wdata = s_value;
            end
            OP_INIT_PUSH: begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = {{IDX_W{1'b0}}, cnt_m1[IDX_W-1:0]};
            end
            OP_POP:         stk_re = 1'b1;
            OP_LATCH_RANGE: begin
                rd_a_en   = 1'b1;
                rd_a_addr = stk_hi;
            end
            OP_SCAN_READ: begin
                rd_a_en = 1'b1;
                rd_b_en = 1'b1;
            end
            OP_SWAP_LO:     mem_we = 1'b1;
            OP_SWAP_HI: begin
                mem_we    = 1'b1;
                mem_waddr = k_reg;
                mem_wdata = rd_b_reg;
            end
            OP_FINAL_READ: begin
                rd_a_en   = 1'b1;
                rd_a_addr = dest_reg;
            end
            OP_FINAL_LO: begin
                mem_we    = 1'b1;
                mem_wdata = pivot_reg;
            end
            OP_FINAL_HI: begin
                mem_we    = 1'b1;
                mem_waddr = hi_reg;
            end
            OP_PUSH_RIGHT: begin
                stk_we    = 1'b1;
                stk_wdata = {dest_reg + IDX_W'(1), hi_reg};
            end
            OP_PUSH_LEFT: begin
                stk_we    = 1'b1;
                stk_wdata = {lo_reg, dest_reg - IDX_W'(1)};
            end
            OP_OUT_READ: begin
                rd_a_en   = 1'b1;
                rd_a_addr = out_idx_reg;
            end
            OP_OUT_NEXT: begin
                rd_a_en   = 1'b1;
                rd_a_addr = out_idx_reg + IDX_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            elem_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_a_en) begin
            rd_a_reg <= elem_mem[rd_a_addr];
        end
        if (rd_b_en) begin
            rd_b_reg <= elem_mem[rd_b_addr];
        end
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rd_reg <= stk_mem[sp_reg - IDX_W'(1)];
        end
    end

    // Partition indexes, pivot and output payload.
    always_ff @(posedge aclk) begin
        case (op)
            OP_LATCH_RANGE: begin
                lo_reg   <= stk_lo;
                hi_reg   <= stk_hi;
                k_reg    <= stk_lo;
                dest_reg <= stk_lo;
            end
            OP_LATCH_PIVOT: pivot_reg <= rd_a_reg;
            OP_SWAP_HI: begin
                k_reg    <= k_reg + IDX_W'(1);
                dest_reg <= dest_reg + IDX_W'(1);
            end
            OP_SKIP:        k_reg <= k_reg + IDX_W'(1);
            OP_OUT_LOAD: begin
                m_value_reg <= rd_a_reg;
                m_last_reg  <= CNT_W'(out_idx_reg) == cnt_m1;
                m_user_reg  <= ovf_reg;
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            sp_reg      <= '0;
            out_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (op)
                OP_LOAD: begin
                    if (not_full) begin
                        count_reg <= count_reg + CNT_W'(1);
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                end
                OP_INIT_PUSH:  sp_reg <= IDX_W'(1);
                OP_POP:        sp_reg <= sp_reg - IDX_W'(1);
                OP_PUSH_RIGHT,
                OP_PUSH_LEFT:  sp_reg <= sp_reg + IDX_W'(1);
                OP_OUT_NEXT:   out_idx_reg <= out_idx_reg + IDX_W'(1);
                OP_CLEAR: begin
                    count_reg   <= '0;
                    ovf_reg     <= 1'b0;
                    sp_reg      <= '0;
                    out_idx_reg <= '0;
                end
                default: begin
                end
            endcase
            if (op == OP_OUT_LOAD) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;
    assign m_user  = m_user_reg;

    // Disjoint ranges of two or more elements bound the live stack depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (IDX_W + 1)'(sp_reg) <= (IDX_W + 1)'(MAX_ITEMS / 2))
        else $error("range stack deeper than half the store");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_SCAN_READ) |-> (k_reg < hi_reg && dest_reg <= k_reg))
        else $error("scan index outside its range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_OUT_LOAD) |-> !m_valid_reg)
        else $error("pending result overwritten");

endmodule

// ===== sv/qse_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the quicksort engine: load, partition loop and emission.
module qse_ctrl
    import qse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    input  qse_status_t status,
    output qse_op_t     op
);

    typedef enum logic [14:0] {
        ST_LOAD     = 15'h0001,
        ST_INIT     = 15'h0002,
        ST_POP      = 15'h0004,
        ST_RANGE    = 15'h0008,
        ST_PIVOT    = 15'h0010,
        ST_SCAN     = 15'h0020,
        ST_CMP      = 15'h0040,
        ST_SWAP     = 15'h0080,
        ST_FIN_LO   = 15'h0100,
        ST_FIN_HI   = 15'h0200,
        ST_PUSH_R   = 15'h0400,
        ST_PUSH_L   = 15'h0800,
        ST_OUT_RD   = 15'h1000,
        ST_OUT_LOAD = 15'h2000,
        ST_OUT_HOLD = 15'h4000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = state_reg == ST_LOAD;

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    op = OP_LOAD;
                    if (s_tlast) begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                if (status.count_ge2) begin
                    op         = OP_INIT_PUSH;
                    state_next = ST_POP;
                end else begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_POP: begin
                if (status.sp_zero) begin
                    state_next = ST_OUT_RD;
                end else begin
                    op         = OP_POP;
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                op         = OP_LATCH_RANGE;
                state_next = ST_PIVOT;
            end
            ST_PIVOT: begin
                op         = OP_LATCH_PIVOT;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (status.k_eq_hi) begin
                    op         = OP_FINAL_READ;
                    state_next = ST_FIN_LO;
                end else begin
                    op         = OP_SCAN_READ;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (status.less) begin
                    op         = OP_SWAP_LO;
                    state_next = ST_SWAP;
                end else begin
                    op         = OP_SKIP;
                    state_next = ST_SCAN;
                end
            end
            ST_SWAP: begin
                op         = OP_SWAP_HI;
                state_next = ST_SCAN;
            end
            ST_FIN_LO: begin
                op         = OP_FINAL_LO;
                state_next = ST_FIN_HI;
            end
            ST_FIN_HI: begin
                op         = OP_FINAL_HI;
                state_next = ST_PUSH_R;
            end
            ST_PUSH_R: begin
                if (status.right_ok) begin
                    op = OP_PUSH_RIGHT;
                end
                state_next = ST_PUSH_L;
            end
            ST_PUSH_L: begin
                if (status.left_ok) begin
                    op = OP_PUSH_LEFT;
                end
                state_next = ST_POP;
            end
            ST_OUT_RD: begin
                op         = OP_OUT_READ;
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
                op         = OP_OUT_LOAD;
                state_next = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (status.out_taken) begin
                    if (status.out_last) begin
                        op         = OP_CLEAR;
                        state_next = ST_LOAD;
                    end else begin
                        op         = OP_OUT_NEXT;
                        state_next = ST_OUT_LOAD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sim/quicksort_engine_checker.sv =====
`timescale 1ns / 1ps
// Checker for the quicksort engine: predicts each sorted run from the input stream and compares.
module quicksort_engine_checker
    import qse_pkg::*;
#(
    parameter int  MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int  DATA_WIDTH = DEF_DATA_WIDTH,
    localparam int TDATA_W    = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [DATA_WIDTH-1:0] value
    input  logic               s_tlast,   // last_item
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,   // [DATA_WIDTH-1:0] sorted_value
    input  logic               m_tlast,   // last_result
    input  logic [0:0]         m_tuser,   // [0] dropped
    output int                 errors,
    output int                 pending,
    output int                 results_seen
);

    typedef logic signed [DATA_WIDTH-1:0] elem_t;

    typedef struct packed {
        elem_t value;
        logic  last;
        logic  dropped;
    } sorted_out_t;

    elem_t       held [MAX_ITEMS];
    int          held_count;
    logic        lost_some;
    sorted_out_t sorted_due [$];
    int          err_cnt;
    int          seen_cnt;

    // The set is sorted in ascending signed order; any correct sort gives the same sequence,
    // and every result of the run carries the overflow flag of the set.
    function automatic void close_set();
        elem_t       order [MAX_ITEMS];
        elem_t       v;
        int          i;
        int          j;
        sorted_out_t r;
        for (i = 0; i < held_count; i++) begin
            order[i] = held[i];
        end
        for (i = 1; i < held_count; i++) begin
            v = order[i];
            j = i - 1;
            while (j >= 0 && order[j] > v) begin
                order[j + 1] = order[j];
                j--;
            end
            order[j + 1] = v;
        end
        for (i = 0; i < held_count; i++) begin
            r.value   = order[i];
            r.last    = (i == held_count - 1);
            r.dropped = lost_some;
            sorted_due.push_back(r);
        end
    endfunction

    function automatic void report_mismatch(string what, sorted_out_t want,
                                            elem_t got_v, logic got_l, logic got_d);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("checker: %s at result %0d: expected value %0d last %0b dropped %0b, got value %0d last %0b dropped %0b",
                     what, seen_cnt, $signed(want.value), want.last, want.dropped,
                     $signed(got_v), got_l, got_d);
        end
    endfunction

    always @(posedge aclk) begin
        sorted_out_t want;
        elem_t       got_v;
        if (!aresetn) begin
            held_count = 0;
            lost_some  = 1'b0;
            sorted_due.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                if (held_count < MAX_ITEMS) begin
                    held[held_count] = s_tdata[DATA_WIDTH-1:0];
                    held_count++;
                end else begin
                    lost_some = 1'b1;
                end
                if (s_tlast) begin
                    close_set();
                    held_count = 0;
                    lost_some  = 1'b0;
                end
            end
            if (m_tvalid && m_tready) begin
                seen_cnt++;
                got_v = m_tdata[DATA_WIDTH-1:0];
                if (sorted_due.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, got_v, m_tlast,
                                    m_tuser[0]);
                end else begin
                    want = sorted_due.pop_front();
                    if (got_v !== want.value || m_tlast !== want.last
                            || m_tuser[0] !== want.dropped) begin
                        report_mismatch("mismatch", want, got_v, m_tlast, m_tuser[0]);
                    end
                end
            end
        end
        errors       <= err_cnt;
        pending      <= sorted_due.size();
        results_seen <= seen_cnt;
    end

endmodule

// ===== sim/quicksort_engine_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the quicksort engine: clock, reset, stream stimulus, back-pressure and verdict.
module quicksort_engine_core_test;
    import qse_pkg::*;

    localparam int MAX_ITEMS      = DEF_MAX_ITEMS;
    localparam int DATA_WIDTH     = DEF_DATA_WIDTH;
    localparam int TDATA_W        = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int ITEM_TARGET    = 400;
    // A 64-element set already in order is the slowest sort.
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_RESULT = 25;
    localparam int DRAIN_CYCLES   = 50;

    typedef enum int {
        FILL_WIDE,
        FILL_DUPS,
        FILL_EDGES,
        FILL_RISING,
        FILL_FALLING
    } fill_style_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;    // [DATA_WIDTH-1:0] value
    logic               s_tlast;    // last_item
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;    // [DATA_WIDTH-1:0] sorted_value
    logic               m_tlast;    // last_result
    logic [0:0]         m_tuser;    // [0] dropped

    int   errors;
    int   pending;
    int   results_seen;
    int   items_sent;
    int   sets_sent;
    int   overflow_sets;
    int   idle_cycles;
    logic sender_steady;
    logic receiver_steady;

    quicksort_engine_core #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    quicksort_engine_checker #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DATA_WIDTH (DATA_WIDTH)
    ) chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Any stretch this long without a transaction on either channel means the engine hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one value and returns at the edge where the transaction completes. The valid
    // line stays high into the next item when no gap is drawn.
    task automatic send_item(input logic [DATA_WIDTH-1:0] v, input logic closes);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(v);
        s_tlast  <= closes;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (closes) begin
            sets_sent++;
        end
    endtask

    // Drops valid and waits until every predicted result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic send_set(input int size, input fill_style_t style);
        logic [DATA_WIDTH-1:0] base;
        logic [DATA_WIDTH-1:0] v;
        int                    k;
        base          = $urandom;
        sender_steady = ($urandom_range(0, 3) == 0);
        if (size > MAX_ITEMS) begin
            overflow_sets++;
        end
        for (k = 0; k < size; k++) begin
            case (style)
                FILL_WIDE: begin
                    v = $urandom;
                end
                FILL_DUPS: begin
                    v = $urandom_range(0, 6) - 3;
                end
                FILL_EDGES: begin
                    case ($urandom_range(0, 5))
                        0: v = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
                        1: v = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
                        2: v = '1;
                        3: v = '0;
                        4: v = 1;
                        default: v = $urandom;
                    endcase
                end
                FILL_RISING: begin
                    v = base + k;
                end
                default: begin
                    v = base - k;
                end
            endcase
            send_item(v, k == size - 1);
        end
    endtask

    // Result side: a random wait before each transaction, steady stretches, and one long
    // hold-off while the sender keeps offering the next set, so the engine backs up.
    initial begin
        int gap;
        int taken;
        m_tready        <= 1'b0;
        receiver_steady  = 1'b0;
        taken            = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (taken % 16 == 0) begin
                receiver_steady = ($urandom_range(0, 2) == 0);
            end
            gap = receiver_steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
            if (taken == HOLD_AT_RESULT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
        end
    end

    initial begin
        int          set_idx;
        int          size;
        int          pick;
        fill_style_t style;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tlast       <= 1'b0;
        aresetn       <= 1'b0;
        items_sent     = 0;
        sets_sent      = 0;
        overflow_sets  = 0;
        sender_steady  = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sets: a lone element, the signed extremes around zero, all-equal values,
        // input already in order and input in reverse order.
        send_item({1'b0, {(DATA_WIDTH - 1){1'b1}}}, 1'b1);
        send_item({1'b0, {(DATA_WIDTH - 1){1'b1}}}, 1'b0);
        send_item({1'b1, {(DATA_WIDTH - 1){1'b0}}}, 1'b0);
        send_item('1, 1'b0);
        send_item('0, 1'b0);
        send_item(1, 1'b1);
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(5, 1'b1);
        send_item(-3, 1'b0);
        send_item(-2, 1'b0);
        send_item(-1, 1'b0);
        send_item(0, 1'b1);
        send_item(100, 1'b0);
        send_item(50, 1'b0);
        send_item(0, 1'b0);
        send_item(-50, 1'b1);
        drain_results();

        // Random sets, mostly small. A few fill the store exactly, and a few run past it,
        // including one where only the closing transaction is discarded.
        set_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            style = fill_style_t'($urandom_range(0, 4));
            pick  = $urandom_range(0, 19);
            if (set_idx == 0) begin
                size = 20;
            end else if (set_idx == 2) begin
                size = MAX_ITEMS;
            end else if (set_idx == 5) begin
                size = MAX_ITEMS + 1;
            end else if (set_idx == 9) begin
                size = MAX_ITEMS + 6;
            end else if (pick == 0) begin
                size = MAX_ITEMS;
            end else if (pick == 1) begin
                size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
            end else begin
                size = $urandom_range(1, 12);
            end
            send_set(size, style);
            // Now and then the sender waits for the engine to empty completely.
            if (set_idx % 7 == 6) begin
                drain_results();
            end
            set_idx++;
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d values in %0d sets sent, %0d of those sets overran the store",
                 items_sent, sets_sent, overflow_sets);
        $display("summary: %0d sorted results checked, %0d mismatches", results_seen, errors);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
